/* sv/bdc_pkg.sv */
// Shared types and constants for the dot-cell operand parser.
// No dependencies; imported by every module of the block.
package bdc_pkg;

   localparam int unsigned CODE_W   = 21;
   localparam int unsigned CELL_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [COUNT_W-1:0] MAX_CELLS = COUNT_W'(255);

   localparam logic [CODE_W-1:0] DIGIT_ONE   = CODE_W'(8'h31);
   localparam logic [CODE_W-1:0] DIGIT_EIGHT = CODE_W'(8'h38);

   localparam logic [CODE_W-1:0] SPACE_RESET     = CODE_W'(48);
   localparam logic [CODE_W-1:0] DELIMITER_RESET = CODE_W'(45);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPACE     = 1'b0,
      CSR_DELIMITER = 1'b1
   } bdc_csr_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_CELL     = 3'd0,
      ST_INVALID  = 3'd1,
      ST_REPEATED = 3'd2,
      ST_MISSING  = 3'd3,
      ST_TOO_MANY = 3'd4
   } bdc_status_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_bits;
      bdc_status_type    status;
      logic              last;
   } bdc_result_type;

endpackage

/* sv/braille_dot_cells_parser.sv */
// Dot-cell operand parser top level: configuration registers, parse step
// and result register. Uses bdc_pkg, bdc_step and bdc_out.
//
//   channel | prefix | direction | beat
//   input   | req_   | in        | one character or end marker
//   result  | rsp_   | out       | one cell byte or error status
//   config  | csr_   | in        | register write, no wait
//
// One beat per cycle in and out; each beat is parsed in the cycle it is
// accepted and its result appears from the result register the next cycle.
// A stalled result register blocks input only while it holds an untaken
// beat that is not being taken this cycle.
// Synchronous active-high reset clears operand state and empties the
// result register; codes return to '0' for space and '-' for delimiter.
module braille_dot_cells_parser import bdc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CODE_W-1:0]    req_char_code,
   input  logic                 req_end_marker,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CELL_W-1:0]    rsp_cell_bits,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_last,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CODE_W-1:0]    csr_wdata
);

   logic [CODE_W-1:0] space_ff;
   logic [CODE_W-1:0] delim_ff;
   logic              can_load;
   logic              accept;
   logic              res_valid;
   bdc_result_type    res;

   always_ff @(posedge clock) begin
      if (reset) begin
         space_ff <= SPACE_RESET;
         delim_ff <= DELIMITER_RESET;
      end else if (csr_write_en) begin
         unique case (bdc_csr_type'(csr_index))
            CSR_SPACE:     space_ff <= csr_wdata;
            CSR_DELIMITER: delim_ff <= csr_wdata;
            default:       space_ff <= space_ff;
         endcase
      end
   end

   assign req_ready = can_load;
   assign accept    = req_valid && can_load;

   bdc_step u_step (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .char_code      (req_char_code),
      .end_marker     (req_end_marker),
      .space_code     (space_ff),
      .delimiter_code (delim_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   bdc_out u_out (
      .clock         (clock),
      .reset         (reset),
      .load          (res_valid),
      .res           (res),
      .can_load      (can_load),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_bits (rsp_cell_bits),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule

/* sv/bdc_step.sv */
// Per-character parse step: operand state registers and the decode that
// turns one accepted beat into at most one result. Uses bdc_pkg.
module bdc_step import bdc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [CODE_W-1:0]   char_code,
   input  logic                end_marker,
   input  logic [CODE_W-1:0]   space_code,
   input  logic [CODE_W-1:0]   delimiter_code,
   output logic                res_valid,
   output bdc_result_type      res
);

   logic [CELL_W-1:0]  acc_ff, acc_in;
   logic               started_ff, started_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               skip_ff, skip_in;

   logic               is_digit;
   logic [2:0]         dot_idx;
   logic [CELL_W-1:0]  dot;

   assign is_digit = (char_code >= DIGIT_ONE) && (char_code <= DIGIT_EIGHT);
   assign dot_idx  = char_code[2:0] - 3'd1;
   assign dot      = CELL_W'(1) << dot_idx;

   always_comb begin
      acc_in     = acc_ff;
      started_in = started_ff;
      count_in   = count_ff;
      skip_in    = skip_ff;
      res_valid  = 1'b0;
      res        = '{cell_bits: '0, status: ST_INVALID, last: 1'b1};
      if (accept) begin
         priority if (end_marker) begin
            if (!skip_ff) begin
               res_valid = 1'b1;
               if (!started_ff) begin
                  res.status = ST_MISSING;
               end else begin
                  res.status    = ST_CELL;
                  res.cell_bits = acc_ff;
               end
            end
            acc_in     = '0;
            started_in = 1'b0;
            count_in   = '0;
            skip_in    = 1'b0;
         end else if (skip_ff) begin
            res_valid = 1'b0;
         end else if (is_digit) begin
            if (started_ff && acc_ff == '0) begin
               res_valid = 1'b1;
               skip_in   = 1'b1;
            end else if ((acc_ff & dot) != '0) begin
               res_valid  = 1'b1;
               res.status = ST_REPEATED;
               skip_in    = 1'b1;
            end else begin
               acc_in     = acc_ff | dot;
               started_in = 1'b1;
            end
         end else if (char_code == space_code) begin
            if (started_ff) begin
               res_valid = 1'b1;
               skip_in   = 1'b1;
            end else begin
               started_in = 1'b1;
            end
         end else if (char_code == delimiter_code) begin
            res_valid = 1'b1;
            if (!started_ff) begin
               res.status = ST_MISSING;
               skip_in    = 1'b1;
            end else if (count_ff >= MAX_CELLS - COUNT_W'(1)) begin
               res.status = ST_TOO_MANY;
               skip_in    = 1'b1;
            end else begin
               res.status    = ST_CELL;
               res.cell_bits = acc_ff;
               res.last      = 1'b0;
               count_in      = count_ff + COUNT_W'(1);
               acc_in        = '0;
               started_in    = 1'b0;
            end
         end else begin
            res_valid = 1'b1;
            skip_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         started_ff <= 1'b0;
         count_ff   <= '0;
         skip_ff    <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         started_ff <= started_in;
         count_ff   <= count_in;
         skip_ff    <= skip_in;
      end
   end

   a_drop_while_skipping: assert property (@(posedge clock) disable iff (reset)
      accept && skip_ff && !end_marker |-> !res_valid)
      else $error("result produced while dropping after error");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status != ST_CELL |->
         res.cell_bits == '0 && res.last && (end_marker || skip_in))
      else $error("error result malformed or not followed by drop");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_marker |=> acc_ff == '0 && !started_ff && count_ff == '0 && !skip_ff)
      else $error("operand state not cleared after end beat");

endmodule

/* sv/bdc_out.sv */
// Result register: holds one result beat until the consumer takes it and
// reports when a new result may be loaded. Uses bdc_pkg.
module bdc_out import bdc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  bdc_result_type      res,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CELL_W-1:0]   rsp_cell_bits,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   logic           valid_ff, valid_in;
   bdc_result_type data_ff;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_cell_bits = data_ff.cell_bits;
   assign rsp_status    = data_ff.status;
   assign rsp_last      = data_ff.last;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !valid_ff)
      else $error("result register not empty after reset");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("result loaded over a pending beat");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ready && !load |=> !valid_ff)
      else $error("taken beat still presented");

endmodule
